// ===== rtl/avc_pkg.sv =====
package avc_pkg;

    localparam int ALPHABET_DEPTH_DEF = 64;
    localparam int KEY_DEPTH_DEF      = 64;
    localparam int DEFAULT_SIZE       = 26;

    localparam logic [7:0] CHAR_UP_A = 8'h41;
    localparam logic [7:0] CHAR_UP_Z = 8'h5a;
    localparam logic [7:0] CHAR_LO_A = 8'h61;
    localparam logic [7:0] CHAR_LO_Z = 8'h7a;
    localparam logic [7:0] CHAR_TAB  = 8'h09;
    localparam logic [7:0] CHAR_CR   = 8'h0d;
    localparam logic [7:0] CHAR_SP   = 8'h20;
    localparam logic [7:0] CASE_GAP  = 8'h20;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_ALPHA  = 2'd1,
        OP_KEY    = 2'd2,
        OP_CIPHER = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_DONE      = 3'd0,
        ST_PASS      = 3'd1,
        ST_IGNORED   = 3'd2,
        ST_FULL      = 3'd3,
        ST_NOT_READY = 3'd4
    } t_status;

    typedef struct packed {
        t_op        operation;
        logic [7:0] character;
    } t_in_word;

    typedef struct packed {
        logic [7:0] result_char;
        t_status    status;
    } t_out_word;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_MOD,
        S_FIN
    } t_state;

    typedef struct packed {
        logic capture;
        logic load_sh;
        logic sub_sh;
        logic calc_idx;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic cipher_go;
        logic sh_ge_n;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== rtl/alphabet_vigenere_cipher_core.sv =====
// steps: capture, evaluate, for a ciphered word k shift reductions (one subtract per cycle) and the
// index, then finish into the output register; k is 0 unless the key was loaded against the default
// alphabet and letters came later (then at most 12)
// one word in flight; the next word is taken in the cycle after its result is stored, and the
// finish step waits while the result side stalls with a result still held
// reset: synchronous, active low; alphabet and key empty, key position 0, encrypt mode on
module alphabet_vigenere_cipher_core
    import avc_pkg::*;
#(
    parameter int ALPHABET_DEPTH = ALPHABET_DEPTH_DEF,
    parameter int KEY_DEPTH      = KEY_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    // configuration: encrypt mode
    input  logic      i_cfg_wr_en,
    input  logic      i_cfg_wr_data,
    // input words
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    // result words
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    // command and status between the sequencer and the datapath
    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // sequencer: capture, evaluate, reduce shift, finish into the output register
    avc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    // datapath: alphabet memory with a reverse lookup memory and seen bits,
    // key shift memory, modular index unit and the output register
    avc_datapath #(
        .ALPHABET_DEPTH (ALPHABET_DEPTH),
        .KEY_DEPTH      (KEY_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_word     (i_in_word),
        .i_cmd         (dp_cmd),
        .o_sts         (dp_sts),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_out_word    (o_out_word)
    );

endmodule

// ===== rtl/avc_ctrl.sv =====
module avc_ctrl
    import avc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_sts.cipher_go) begin
                    o_cmd.load_sh = 1'b1;
                    n_state       = S_MOD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_MOD: begin
                // reduce the key shift into the current alphabet size
                if (i_sts.sh_ge_n) begin
                    o_cmd.sub_sh = 1'b1;
                end else begin
                    o_cmd.calc_idx = 1'b1;
                    n_state        = S_FIN;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/avc_datapath.sv =====
module avc_datapath
    import avc_pkg::*;
#(
    parameter int ALPHABET_DEPTH = ALPHABET_DEPTH_DEF,
    parameter int KEY_DEPTH      = KEY_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_wr_en,
    input  logic      i_cfg_wr_data,
    input  t_in_word  i_in_word,
    input  t_dp_cmd   i_cmd,
    output t_dp_sts   o_sts,
    input  logic      i_out_stall,
    output logic      o_out_valid,
    output t_out_word o_out_word
);

    localparam int AW  = $clog2(ALPHABET_DEPTH);
    localparam int ACW = $clog2(ALPHABET_DEPTH + 1);
    localparam int SW  = (AW > 5) ? AW : 5;
    localparam int NW  = (ACW > 5) ? ACW : 5;
    localparam int KIW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int KCW = $clog2(KEY_DEPTH + 1);

    function automatic logic [7:0] fold_up(input logic [7:0] c);
        if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
            return c - CASE_GAP;
        end
        return c;
    endfunction

    // memories
    logic [7:0]    r_alpha_mem [ALPHABET_DEPTH];
    logic [AW-1:0] r_look_mem  [256];
    logic [SW-1:0] r_key_mem   [KEY_DEPTH];

    logic [255:0]   r_seen;
    logic [ACW-1:0] r_alpha_cnt;
    logic [KCW-1:0] r_key_cnt;
    logic [KIW-1:0] r_key_pos;
    logic           r_encrypt;

    t_op           r_op;
    logic [7:0]    r_ch;
    logic [7:0]    r_up;
    logic [AW-1:0] r_look_rd;
    logic [SW-1:0] r_key_rd;
    logic [NW-1:0] r_sh;
    logic [NW-1:0] r_idx;
    logic [7:0]    r_alpha_rd;

    logic      r_out_valid;
    t_out_word r_out_word;

    logic          alpha_empty;
    logic          alpha_one;
    logic          key_ready;
    logic          found;
    logic [NW-1:0] pos;
    logic [NW-1:0] size_n;
    logic [NW:0]   idx_sum;
    logic [NW-1:0] n_idx;

    logic       do_clear;
    logic       do_alpha_wr;
    logic       do_key_wr;
    logic       do_advance;
    t_out_word  n_out_word;
    logic [7:0] mapped;
    logic [KIW:0]   kp_inc;
    logic [KIW-1:0] n_key_pos;

    assign alpha_empty = (r_alpha_cnt == '0);
    assign alpha_one   = (r_alpha_cnt == ACW'(1));
    assign key_ready   = !alpha_one && (r_key_cnt != '0);
    assign found       = alpha_empty ? (r_up >= CHAR_UP_A && r_up <= CHAR_UP_Z) : r_seen[r_up];
    assign pos         = alpha_empty ? NW'(r_up - CHAR_UP_A) : NW'(r_look_rd);
    assign size_n      = alpha_empty ? NW'(DEFAULT_SIZE) : NW'(r_alpha_cnt);

    assign o_sts.cipher_go = (r_op == OP_CIPHER) && key_ready && found;
    assign o_sts.sh_ge_n   = (r_sh >= size_n);
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    // shifted index, both operands below the size so one correction suffices
    always_comb begin
        if (r_encrypt) begin
            idx_sum = {1'b0, pos} + {1'b0, r_sh};
        end else begin
            idx_sum = {1'b0, pos} + {1'b0, size_n} - {1'b0, r_sh};
        end
        if (idx_sum >= {1'b0, size_n}) begin
            n_idx = NW'(idx_sum - {1'b0, size_n});
        end else begin
            n_idx = NW'(idx_sum);
        end
    end

    always_comb begin
        do_clear    = 1'b0;
        do_alpha_wr = 1'b0;
        do_key_wr   = 1'b0;
        do_advance  = 1'b0;
        n_out_word.result_char = r_ch;
        n_out_word.status      = ST_DONE;
        mapped = alpha_empty ? (CHAR_UP_A + 8'(r_idx)) : r_alpha_rd;
        if (r_ch >= CHAR_LO_A && r_ch <= CHAR_LO_Z && mapped >= CHAR_UP_A
                && mapped <= CHAR_UP_Z) begin
            mapped = mapped + CASE_GAP;
        end
        kp_inc = {1'b0, r_key_pos} + (KIW+1)'(1);
        if (kp_inc >= (KIW+1)'(r_key_cnt)) begin
            n_key_pos = '0;
        end else begin
            n_key_pos = kp_inc[KIW-1:0];
        end
        case (r_op)
            OP_CLEAR: begin
                do_clear = 1'b1;
            end
            OP_ALPHA: begin
                if ((r_ch >= CHAR_TAB && r_ch <= CHAR_CR) || r_ch == CHAR_SP) begin
                    n_out_word.status = ST_IGNORED;
                end else if (r_seen[r_up]) begin
                    n_out_word.status = ST_IGNORED;
                end else if (r_alpha_cnt >= ACW'(ALPHABET_DEPTH)) begin
                    n_out_word.status = ST_FULL;
                end else begin
                    do_alpha_wr = 1'b1;
                end
            end
            OP_KEY: begin
                if (alpha_one) begin
                    n_out_word.status = ST_NOT_READY;
                end else if (!found) begin
                    n_out_word.status = ST_IGNORED;
                end else if (r_key_cnt >= KCW'(KEY_DEPTH)) begin
                    n_out_word.status = ST_FULL;
                end else begin
                    do_key_wr = 1'b1;
                end
            end
            default: begin
                if (!key_ready) begin
                    n_out_word.status = ST_NOT_READY;
                end else if (!found) begin
                    n_out_word.status = ST_PASS;
                end else begin
                    n_out_word.result_char = mapped;
                    do_advance             = 1'b1;
                end
            end
        endcase
    end

    // memory ports and payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op      <= i_in_word.operation;
            r_ch      <= i_in_word.character;
            r_up      <= fold_up(i_in_word.character);
            r_look_rd <= r_look_mem[fold_up(i_in_word.character)];
            r_key_rd  <= r_key_mem[r_key_pos];
        end
        if (i_cmd.load_sh) begin
            r_sh <= NW'(r_key_rd);
        end else if (i_cmd.sub_sh) begin
            r_sh <= r_sh - size_n;
        end
        if (i_cmd.calc_idx) begin
            r_idx      <= n_idx;
            r_alpha_rd <= r_alpha_mem[n_idx[AW-1:0]];
        end
        if (i_cmd.finish && do_alpha_wr) begin
            r_alpha_mem[r_alpha_cnt[AW-1:0]] <= r_up;
            r_look_mem[r_up]                 <= r_alpha_cnt[AW-1:0];
        end
        if (i_cmd.finish && do_key_wr) begin
            r_key_mem[r_key_cnt[KIW-1:0]] <= SW'(pos);
        end
        if (i_cmd.finish) begin
            r_out_word <= n_out_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen      <= '0;
            r_alpha_cnt <= '0;
            r_key_cnt   <= '0;
            r_key_pos   <= '0;
            r_encrypt   <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_encrypt <= i_cfg_wr_data;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.finish && do_clear) begin
                r_seen      <= '0;
                r_alpha_cnt <= '0;
                r_key_cnt   <= '0;
                r_key_pos   <= '0;
            end
            if (i_cmd.finish && do_alpha_wr) begin
                r_seen[r_up] <= 1'b1;
                r_alpha_cnt  <= r_alpha_cnt + ACW'(1);
            end
            if (i_cmd.finish && do_key_wr) begin
                r_key_cnt <= r_key_cnt + KCW'(1);
            end
            if (i_cmd.finish && do_advance) begin
                r_key_pos <= n_key_pos;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ===== rtl/avc_checker.sv =====
module avc_checker
    import avc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_word o_out_word
);

    // held result stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // held result does not change
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_word))
        else $error("result changed while stalled");

    // one word at a time: input side closes right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second word taken while one is in flight");

    // a new result only appears while a word is in flight
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without a word in flight");

endmodule

bind alphabet_vigenere_cipher_core avc_checker u_avc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);
